>>> sv/quaternion_gyro_integrator_macros.svh
// Assertion macros shared by the quaternion gyro integrator RTL.
`ifndef QUATERNION_GYRO_INTEGRATOR_MACROS_SVH
`define QUATERNION_GYRO_INTEGRATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QGI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define QGI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/qgi_pkg.sv
// Types and constants of the quaternion gyro integrator.
`timescale 1ns / 1ps
package qgi_pkg;

  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam logic [31:0] SAT_P = 32'd2147483647;
  localparam logic [15:0] PERIOD_RESET = 16'd16777;

  // Operand pair handed to the shared multiplier.
  typedef struct packed {
    logic [32:0] a;
    logic [32:0] b;
  } mul_req_t;

endpackage

>>> sv/qgi_rate_if.sv
// Gyro sample channel: valid, ready and three angular rates.
`timescale 1ns / 1ps
interface qgi_rate_if;
  logic valid;
  logic ready;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

>>> sv/qgi_quat_if.sv
// Attitude quaternion channel: valid, ready and four Q1.30 components.
`timescale 1ns / 1ps
interface qgi_quat_if;
  logic valid;
  logic ready;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;

  modport source (output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                  input ready);
  modport sink (input valid, input quat_w, input quat_x, input quat_y, input quat_z,
                output ready);
endinterface

>>> sv/qgi_mul.sv
// Shared 33 x 33 signed multiplier with a registered product.
`timescale 1ns / 1ps
module qgi_mul (
  input  logic               clk,
  input  qgi_pkg::mul_req_t  req,
  output logic signed [65:0] prod
);

  always_ff @(posedge clk) begin
    prod <= $signed(req.a) * $signed(req.b);
  end

endmodule

>>> sv/quaternion_gyro_integrator.sv
// Top level of the quaternion gyro integrator.
`timescale 1ns / 1ps
`include "quaternion_gyro_integrator_macros.svh"
// Usage:
// Each transaction on rate_in carries one gyro sample (rate_x, rate_y, rate_z,
// signed, 2^-12 rad/s per unit). The block scales the rates by sample_period,
// applies the second-order quaternion update to the stored attitude,
// normalizes it, and sends the new attitude on quat_out as one transaction.
// sample_period must be written through cfg_we / cfg_data while the block is
// idle; the block itself does not enforce this. All arithmetic runs through
// one shared registered multiplier, a one-bit-per-cycle square root and a
// one-bit-per-cycle divider under a small sequencer. One sample runs through
// the angle increments, their squares, the matrix product, the norm sum, the
// square root, the four divisions and the output register load. When every
// product row is zero the divisions are skipped and the attitude returns to
// identity. rate_in is ready only while the sequencer is idle, so a new
// sample is accepted only after the previous one is in the output register.
// The result sits in an output register; a stalled receiver holds it there
// while the next sample may already be accepted, and the sequencer waits at
// its end until that register is free. Synchronous reset loads the identity
// attitude and the default sample period, and clears all valid flags.
module quaternion_gyro_integrator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  qgi_rate_if.sink    rate_in,
  qgi_quat_if.source  quat_out
);

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_DMUL    = 5'd1;
  localparam logic [4:0] ST_DSTO    = 5'd2;
  localparam logic [4:0] ST_SQMUL   = 5'd3;
  localparam logic [4:0] ST_SQACC   = 5'd4;
  localparam logic [4:0] ST_CH      = 5'd5;
  localparam logic [4:0] ST_MMUL    = 5'd6;
  localparam logic [4:0] ST_MACC    = 5'd7;
  localparam logic [4:0] ST_PSAT    = 5'd8;
  localparam logic [4:0] ST_PSQMUL  = 5'd9;
  localparam logic [4:0] ST_PSQACC  = 5'd10;
  localparam logic [4:0] ST_SQRT    = 5'd11;
  localparam logic [4:0] ST_NCHK    = 5'd12;
  localparam logic [4:0] ST_DIVINIT = 5'd13;
  localparam logic [4:0] ST_DIV     = 5'd14;
  localparam logic [4:0] ST_DIVSTO  = 5'd15;
  localparam logic [4:0] ST_DONE    = 5'd16;

  logic [4:0]         state;
  logic [15:0]        period;
  logic signed [15:0] rate [3];
  logic signed [31:0] d [3];
  logic signed [31:0] h [3];
  logic signed [31:0] c;
  logic signed [31:0] att [4];
  logic signed [31:0] p [4];
  logic [63:0]        sq;
  logic signed [65:0] acc;
  logic [1:0]         idx;
  logic [1:0]         col;
  logic [4:0]         cnt;
  logic [63:0]        rad;
  logic [33:0]        rem;
  logic [31:0]        root;
  logic [31:0]        n;
  logic [31:0]        drem;
  logic [31:0]        qshift;
  logic               out_valid;
  logic signed [31:0] out_q [4];

  qgi_pkg::mul_req_t  req;
  logic signed [65:0] prod;

  qgi_mul u_mul (
    .clk  (clk),
    .req  (req),
    .prod (prod)
  );

  // Entry of the update matrix at the current row and column.
  logic signed [31:0] m_ent;
  always_comb begin
    case ({idx, col})
      4'b0000, 4'b0101, 4'b1010, 4'b1111: m_ent = c;
      4'b0001: m_ent = -h[0];
      4'b0010: m_ent = -h[1];
      4'b0011: m_ent = -h[2];
      4'b0100: m_ent = h[0];
      4'b0110: m_ent = h[2];
      4'b0111: m_ent = -h[1];
      4'b1000: m_ent = h[1];
      4'b1001: m_ent = -h[2];
      4'b1011: m_ent = h[0];
      4'b1100: m_ent = h[2];
      4'b1101: m_ent = h[1];
      4'b1110: m_ent = -h[0];
      default: m_ent = c;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    req.a = '0;
    req.b = '0;
    case (state)
      ST_DMUL: begin
        req.a = {{17{rate[idx][15]}}, rate[idx]};
        req.b = {17'd0, period};
      end
      ST_SQMUL: begin
        req.a = {d[idx][31], d[idx]};
        req.b = {d[idx][31], d[idx]};
      end
      ST_MMUL: begin
        req.a = {m_ent[31], m_ent};
        req.b = {att[col][31], att[col]};
      end
      ST_PSQMUL: begin
        req.a = {p[idx][31], p[idx]};
        req.b = {p[idx][31], p[idx]};
      end
      default: begin
        req.a = '0;
        req.b = '0;
      end
    endcase
  end

  logic [63:0]        sq_total;
  logic signed [65:0] acc_total;
  logic signed [35:0] p_round;
  logic signed [31:0] p_sat;
  logic [64:0]        sq_rnd;
  logic [35:0]        sqrt_sh;
  logic [35:0]        sqrt_trial;
  logic               sqrt_bit;
  logic [32:0]        div_t;
  logic               div_bit;
  logic [31:0]        p_abs;
  logic [61:0]        dividend;
  logic [31:0]        q_mag;
  logic signed [31:0] q_val;

  always_comb begin
    sq_total   = sq + prod[63:0];
    acc_total  = acc + prod;
    p_round    = 36'((acc_total + 66'sd536870912) >>> 30);
    if (p_round > 36'sd2147483646) begin
      p_sat = 32'sd2147483646;
    end else if (p_round < -36'sd2147483647) begin
      p_sat = -32'sd2147483647;
    end else begin
      p_sat = p_round[31:0];
    end
    sq_rnd     = {1'b0, sq} + 65'h0_1000_0000_0000;
    sqrt_sh    = {rem, rad[63:62]};
    sqrt_trial = {2'b00, root, 2'b01};
    sqrt_bit   = sqrt_sh >= sqrt_trial;
    div_t      = {drem, qshift[31]};
    div_bit    = div_t >= {1'b0, n};
    p_abs      = p[idx][31] ? 32'(-p[idx]) : p[idx];
    dividend   = {p_abs[31:0], 30'd0} + {31'd0, n[31:1]};
    q_mag      = qshift[31] ? qgi_pkg::SAT_P : qshift;
    q_val      = p[idx][31] ? -$signed(q_mag) : $signed(q_mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      period    <= qgi_pkg::PERIOD_RESET;
      out_valid <= 1'b0;
      att[0]    <= qgi_pkg::ONE_Q30;
      att[1]    <= '0;
      att[2]    <= '0;
      att[3]    <= '0;
      idx       <= '0;
      col       <= '0;
      cnt       <= '0;
    end else begin
      if (cfg_we) begin
        period <= cfg_data;
      end
      if (out_valid && quat_out.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (rate_in.valid) begin
            rate[0] <= rate_in.rate_x;
            rate[1] <= rate_in.rate_y;
            rate[2] <= rate_in.rate_z;
            idx     <= '0;
            state   <= ST_DMUL;
          end
        end
        ST_DMUL: state <= ST_DSTO;
        ST_DSTO: begin
          d[idx] <= prod[31:0];
          if (idx == 2'd2) begin
            idx   <= '0;
            sq    <= '0;
            state <= ST_SQMUL;
          end else begin
            idx   <= idx + 2'd1;
            state <= ST_DMUL;
          end
        end
        ST_SQMUL: state <= ST_SQACC;
        ST_SQACC: begin
          sq <= sq_total;
          if (idx == 2'd2) begin
            state <= ST_CH;
          end else begin
            idx   <= idx + 2'd1;
            state <= ST_SQMUL;
          end
        end
        ST_CH: begin
          c <= qgi_pkg::ONE_Q30 - $signed({12'd0, sq_rnd[64:45]});
          for (int k = 0; k < 3; k++) begin
            h[k] <= 32'(($signed({d[k][31], d[k]}) + 33'sd64) >>> 7);
          end
          idx   <= '0;
          col   <= '0;
          acc   <= '0;
          state <= ST_MMUL;
        end
        ST_MMUL: state <= ST_MACC;
        ST_MACC: begin
          acc <= acc_total;
          if (col == 2'd3) begin
            state <= ST_PSAT;
          end else begin
            col   <= col + 2'd1;
            state <= ST_MMUL;
          end
        end
        ST_PSAT: begin
          p[idx] <= p_sat;
          acc    <= '0;
          col    <= '0;
          if (idx == 2'd3) begin
            idx   <= '0;
            sq    <= '0;
            state <= ST_PSQMUL;
          end else begin
            idx   <= idx + 2'd1;
            state <= ST_MMUL;
          end
        end
        ST_PSQMUL: state <= ST_PSQACC;
        ST_PSQACC: begin
          sq <= sq_total;
          if (idx == 2'd3) begin
            rad   <= sq_total;
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= ST_SQRT;
          end else begin
            idx   <= idx + 2'd1;
            state <= ST_PSQMUL;
          end
        end
        ST_SQRT: begin
          rad  <= {rad[61:0], 2'b00};
          rem  <= sqrt_bit ? 34'(sqrt_sh - sqrt_trial) : sqrt_sh[33:0];
          root <= {root[30:0], sqrt_bit};
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            n     <= {root[30:0], sqrt_bit};
            state <= ST_NCHK;
          end
        end
        ST_NCHK: begin
          idx <= '0;
          if (n == '0) begin
            // Every product row is zero: fall back to the identity attitude.
            att[0] <= qgi_pkg::ONE_Q30;
            att[1] <= '0;
            att[2] <= '0;
            att[3] <= '0;
            state  <= ST_DONE;
          end else begin
            state <= ST_DIVINIT;
          end
        end
        ST_DIVINIT: begin
          drem   <= {2'b00, dividend[61:32]};
          qshift <= dividend[31:0];
          cnt    <= '0;
          state  <= ST_DIV;
        end
        ST_DIV: begin
          drem   <= div_bit ? 32'(div_t - {1'b0, n}) : div_t[31:0];
          qshift <= {qshift[30:0], div_bit};
          cnt    <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= ST_DIVSTO;
          end
        end
        ST_DIVSTO: begin
          att[idx] <= q_val;
          if (idx == 2'd3) begin
            state <= ST_DONE;
          end else begin
            idx   <= idx + 2'd1;
            state <= ST_DIVINIT;
          end
        end
        ST_DONE: begin
          if (!out_valid || quat_out.ready) begin
            for (int k = 0; k < 4; k++) begin
              out_q[k] <= att[k];
            end
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rate_in.ready   = (state == ST_IDLE);
  assign quat_out.valid  = out_valid;
  assign quat_out.quat_w = out_q[0];
  assign quat_out.quat_x = out_q[1];
  assign quat_out.quat_y = out_q[2];
  assign quat_out.quat_z = out_q[3];

  // The divider remainder always stays below the norm.
  `QGI_ASSERT_IMP(a_div_rem, clk, rst, state == ST_DIV, drem < n)
  // Division only runs with a nonzero norm.
  `QGI_ASSERT_IMP(a_div_norm, clk, rst, state == ST_DIVINIT, n != '0)
  // A normalized component never exceeds one in Q1.30 by more than one LSB.
  `QGI_ASSERT_IMP(a_quot_range, clk, rst, state == ST_DIVSTO, qshift <= 32'd1073741825)
  // An accepted sample starts the sequencer at once.
  `QGI_ASSERT_NXT(a_start, clk, rst, rate_in.valid && rate_in.ready, state == ST_DMUL)

endmodule
